### rtl/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// Shared widths, codes, controller types and color tables for the Mandelbrot
// escape-time pixel color unit.
// ----------------------------------------------------------------------------
package mep_pkg;

    // Iteration limit and fixed-point format.
    localparam int MAX_ITER  = 180;
    localparam int FRAC_BITS = 40;

    localparam int WORD_W    = 48;                 // signed Q8.40 word
    localparam int HALF_W    = WORD_W / 2;         // partial-product operand width
    localparam int PROD_W    = 2 * WORD_W;         // full unsigned product
    localparam int STEP_W    = 43;                 // pixel step register
    localparam int PIX_W     = 12;                 // pixel column and row
    localparam int MAP_W     = PIX_W + STEP_W;     // pixel times step
    localparam int CAP_LOG2  = 60;                 // product magnitude cap
    localparam int MAG_W     = CAP_LOG2 + 1;       // capped magnitude
    localparam int SUM_W     = 64;                 // wide signed update sums
    localparam int COLOR_W   = 8;
    localparam int COUNT_W   = 8;                  // iter_count field
    localparam int N_W       = $clog2(MAX_ITER + 1);
    localparam int LUT_D     = 1 << N_W;

    localparam logic [MAG_W-1:0] MAG_CAP   = MAG_W'(1) << CAP_LOG2;
    localparam logic [MAG_W:0]   ESC_LIMIT = (MAG_W + 1)'(1) << (FRAC_BITS + 2);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET        = 43'd5497558139;
    localparam logic [WORD_W-1:0] ORIGIN_REAL_RESET = -48'sd2748779069440;
    localparam logic [WORD_W-1:0] ORIGIN_IMAG_RESET = -48'sd1649267441664;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_MUL,
        S_MAP_SUM,
        S_MAP_ADD,
        S_IT_MUL,
        S_IT_SUM,
        S_IT_EVAL,
        S_COLOR
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_pix;
        logic sel_map;
        logic load_c;
        logic eval;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic stop;
        logic out_free;
    } t_dp_stat;

    // Bernstein color tables, indexed by the iteration count.
    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    typedef logic [COLOR_W-1:0] t_lut [LUT_D];

    localparam longint unsigned M4 = longint'(MAX_ITER) * longint'(MAX_ITER) *
                                     longint'(MAX_ITER) * longint'(MAX_ITER);
    localparam longint unsigned M4X2      = 2 * M4;
    localparam longint unsigned RED_COEF  = 9 * 255;
    localparam longint unsigned GRN_COEF  = 15 * 255;
    localparam longint unsigned BLU_COEF  = 17 * 255;
    localparam longint unsigned COLOR_MAX = (1 << COLOR_W) - 1;

    function automatic t_lut f_color_lut(input t_chan ch);
        t_lut            lut;
        longint unsigned nn;
        longint unsigned k;
        longint unsigned q;
        for (int i = 0; i < LUT_D; i++) begin
            lut[i] = '0;
            if (i <= MAX_ITER) begin
                nn = longint'(i);
                k  = longint'(MAX_ITER - i);
                case (ch)
                    CH_RED:   q = (RED_COEF * k * nn * nn * nn) / M4;
                    CH_GREEN: q = (GRN_COEF * k * k * nn * nn) / M4;
                    CH_BLUE:  q = (BLU_COEF * k * k * k * nn) / M4X2;
                    default:  q = 0;
                endcase
                lut[i] = (q > COLOR_MAX) ? COLOR_W'(COLOR_MAX) : COLOR_W'(q);
            end
        end
        return lut;
    endfunction

    localparam t_lut RED_LUT   = f_color_lut(CH_RED);
    localparam t_lut GREEN_LUT = f_color_lut(CH_GREEN);
    localparam t_lut BLUE_LUT  = f_color_lut(CH_BLUE);

endpackage

### rtl/mep_pixel_if.sv
// ----------------------------------------------------------------------------
// mep_pixel_if
// Valid/ready channel carrying one pixel coordinate per transaction.
// ----------------------------------------------------------------------------
interface mep_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [mep_pkg::PIX_W-1:0]  pixel_col;
    logic [mep_pkg::PIX_W-1:0]  pixel_row;

    modport source (output valid, pixel_col, pixel_row, input ready);
    modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

### rtl/mep_color_if.sv
// ----------------------------------------------------------------------------
// mep_color_if
// Valid/ready channel carrying one colored pixel result per transaction.
// ----------------------------------------------------------------------------
interface mep_color_if;
    logic                          valid;
    logic                          ready;
    logic [mep_pkg::COLOR_W-1:0]   red;
    logic [mep_pkg::COLOR_W-1:0]   green;
    logic [mep_pkg::COLOR_W-1:0]   blue;
    logic [mep_pkg::COUNT_W-1:0]   iter_count;

    modport source (output valid, red, green, blue, iter_count, input ready);
    modport sink   (input valid, red, green, blue, iter_count, output ready);
endinterface

### rtl/mandelbrot_escape_pixel_color_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_color_unit
// Escape-time Mandelbrot evaluation of one pixel with Bernstein coloring.
// ----------------------------------------------------------------------------
// Usage:
// A pixel (column, row) enters on i_pix as a valid/ready transaction. It is
// mapped to c = origin + pixel * pixel_step, z = z^2 + c is iterated from zero
// until |z|^2 reaches 4.0 or 180 steps are done, and the count n is turned
// into red, green and blue by table lookup. The result leaves on o_color.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while
// no pixel is in flight; index 0 is the step, 1 and 2 the origin.
// Mapping passes through the multiply, sum and add states; each loop pass
// runs the two multiplier stages and the update, and n + 1 passes are made.
// One pixel is in flight at a time: no new pixel is taken until the result
// of the last one is in the output register.
// The output register holds a finished result while the next pixel is
// already being evaluated; if the receiver still stalls when that pixel is
// done, the unit waits with it. Reset restores the configuration defaults
// and empties the output register.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_color_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mep_pixel_if.sink                         i_pix,
    mep_color_if.source                       o_color
);

    mep_pkg::t_dp_cmd  w_cmd;
    mep_pkg::t_dp_stat w_stat;

    mep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix.valid),
        .o_pix_ready (i_pix.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    mep_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pixel_col  (i_pix.pixel_col),
        .i_pixel_row  (i_pix.pixel_row),
        .o_out_valid  (o_color.valid),
        .i_out_ready  (o_color.ready),
        .o_red        (o_color.red),
        .o_green      (o_color.green),
        .o_blue       (o_color.blue),
        .o_iter_count (o_color.iter_count)
    );

endmodule

### rtl/mep_mul.sv
// ----------------------------------------------------------------------------
// mep_mul
// Two-stage unsigned 48x48 multiplier built from four 24x24 partial products.
// ----------------------------------------------------------------------------
module mep_mul (
    input  logic                          i_clk,
    input  logic [mep_pkg::WORD_W-1:0]    i_a,
    input  logic [mep_pkg::WORD_W-1:0]    i_b,
    output logic [mep_pkg::PROD_W-1:0]    o_prod
);

    logic [mep_pkg::WORD_W-1:0] r_pp_hh;
    logic [mep_pkg::WORD_W-1:0] r_pp_hl;
    logic [mep_pkg::WORD_W-1:0] r_pp_lh;
    logic [mep_pkg::WORD_W-1:0] r_pp_ll;
    logic [mep_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_pp_hh <= i_a[mep_pkg::WORD_W-1:mep_pkg::HALF_W] *
                   i_b[mep_pkg::WORD_W-1:mep_pkg::HALF_W];
        r_pp_hl <= i_a[mep_pkg::WORD_W-1:mep_pkg::HALF_W] * i_b[mep_pkg::HALF_W-1:0];
        r_pp_lh <= i_a[mep_pkg::HALF_W-1:0] * i_b[mep_pkg::WORD_W-1:mep_pkg::HALF_W];
        r_pp_ll <= i_a[mep_pkg::HALF_W-1:0] * i_b[mep_pkg::HALF_W-1:0];
    end

    // The high and low partial products do not overlap, so they are simply
    // concatenated before the two cross terms are added in.
    always_ff @(posedge i_clk) begin
        r_prod <= {r_pp_hh, r_pp_ll}
                + (mep_pkg::PROD_W'(r_pp_hl) << mep_pkg::HALF_W)
                + (mep_pkg::PROD_W'(r_pp_lh) << mep_pkg::HALF_W);
    end

    assign o_prod = r_prod;

endmodule

### rtl/mep_ctrl.sv
// ----------------------------------------------------------------------------
// mep_ctrl
// Sequencer for pixel mapping, the escape-time loop and result hand-off.
// ----------------------------------------------------------------------------
module mep_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pix_valid,
    output logic               o_pix_ready,
    output mep_pkg::t_dp_cmd   o_cmd,
    input  mep_pkg::t_dp_stat  i_stat
);

    mep_pkg::t_state r_state;
    mep_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mep_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_pix_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            mep_pkg::S_IDLE: begin
                o_pix_ready = 1'b1;
                if (i_pix_valid) begin
                    o_cmd.load_pix = 1'b1;
                    n_state        = mep_pkg::S_MAP_MUL;
                end
            end
            mep_pkg::S_MAP_MUL: begin
                o_cmd.sel_map = 1'b1;
                n_state       = mep_pkg::S_MAP_SUM;
            end
            mep_pkg::S_MAP_SUM: begin
                n_state = mep_pkg::S_MAP_ADD;
            end
            mep_pkg::S_MAP_ADD: begin
                o_cmd.load_c = 1'b1;
                n_state      = mep_pkg::S_IT_MUL;
            end
            mep_pkg::S_IT_MUL: begin
                n_state = mep_pkg::S_IT_SUM;
            end
            mep_pkg::S_IT_SUM: begin
                n_state = mep_pkg::S_IT_EVAL;
            end
            mep_pkg::S_IT_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.stop ? mep_pkg::S_COLOR : mep_pkg::S_IT_MUL;
            end
            mep_pkg::S_COLOR: begin
                // Wait here while the previous result still sits unclaimed.
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mep_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mep_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/mep_dp.sv
// ----------------------------------------------------------------------------
// mep_dp
// Datapath: configuration registers, point mapping, z = z^2 + c update with
// three multiplier lanes, escape test, color lookup and output register.
// ----------------------------------------------------------------------------
module mep_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mep_pkg::t_dp_cmd                  i_cmd,
    output mep_pkg::t_dp_stat                 o_stat,
    input  logic                              i_cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [mep_pkg::PIX_W-1:0]         i_pixel_col,
    input  logic [mep_pkg::PIX_W-1:0]         i_pixel_row,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mep_pkg::COLOR_W-1:0]       o_red,
    output logic [mep_pkg::COLOR_W-1:0]       o_green,
    output logic [mep_pkg::COLOR_W-1:0]       o_blue,
    output logic [mep_pkg::COUNT_W-1:0]       o_iter_count
);

    function automatic logic [mep_pkg::SUM_W-1:0] f_sext(
        input logic [mep_pkg::WORD_W-1:0] v
    );
        return {{(mep_pkg::SUM_W - mep_pkg::WORD_W){v[mep_pkg::WORD_W-1]}}, v};
    endfunction

    function automatic logic [mep_pkg::WORD_W-1:0] f_sat(
        input logic [mep_pkg::SUM_W-1:0] v
    );
        logic [mep_pkg::SUM_W-mep_pkg::WORD_W:0] hi;
        hi = v[mep_pkg::SUM_W-1:mep_pkg::WORD_W-1];
        if ((&hi) || !(|hi)) begin
            return v[mep_pkg::WORD_W-1:0];
        end else if (v[mep_pkg::SUM_W-1]) begin
            return {1'b1, {(mep_pkg::WORD_W - 1){1'b0}}};
        end else begin
            return {1'b0, {(mep_pkg::WORD_W - 1){1'b1}}};
        end
    endfunction

    // Product shifted down by the fraction bits, magnitude capped.
    function automatic logic [mep_pkg::MAG_W-1:0] f_mag(
        input logic [mep_pkg::PROD_W-1:0] p
    );
        logic [mep_pkg::PROD_W-1:0] s;
        s = p >> mep_pkg::FRAC_BITS;
        if (s > mep_pkg::PROD_W'(mep_pkg::MAG_CAP)) begin
            return mep_pkg::MAG_CAP;
        end else begin
            return s[mep_pkg::MAG_W-1:0];
        end
    endfunction

    // Configuration registers.
    logic [mep_pkg::STEP_W-1:0]  r_pixel_step;
    logic [mep_pkg::WORD_W-1:0]  r_origin_real;
    logic [mep_pkg::WORD_W-1:0]  r_origin_imag;

    // Per-pixel working registers.
    logic [mep_pkg::PIX_W-1:0]   r_col;
    logic [mep_pkg::PIX_W-1:0]   r_row;
    logic [mep_pkg::WORD_W-1:0]  r_cr;
    logic [mep_pkg::WORD_W-1:0]  r_ci;
    logic [mep_pkg::WORD_W-1:0]  r_zr;
    logic [mep_pkg::WORD_W-1:0]  r_zi;
    logic [mep_pkg::N_W-1:0]     r_n;

    // Output register.
    logic                        r_out_valid;
    logic [mep_pkg::COLOR_W-1:0] r_red;
    logic [mep_pkg::COLOR_W-1:0] r_green;
    logic [mep_pkg::COLOR_W-1:0] r_blue;
    logic [mep_pkg::COUNT_W-1:0] r_iter_count;

    logic [mep_pkg::WORD_W-1:0]  w_zr_mag;
    logic [mep_pkg::WORD_W-1:0]  w_zi_mag;
    logic [mep_pkg::WORD_W-1:0]  w_a0;
    logic [mep_pkg::WORD_W-1:0]  w_b0;
    logic [mep_pkg::WORD_W-1:0]  w_a1;
    logic [mep_pkg::WORD_W-1:0]  w_b1;
    logic [mep_pkg::PROD_W-1:0]  w_p0;
    logic [mep_pkg::PROD_W-1:0]  w_p1;
    logic [mep_pkg::PROD_W-1:0]  w_p2;
    logic [mep_pkg::MAG_W-1:0]   w_rr;
    logic [mep_pkg::MAG_W-1:0]   w_ii;
    logic [mep_pkg::MAG_W-1:0]   w_ri;
    logic [mep_pkg::MAG_W:0]     w_mag_sum;
    logic [mep_pkg::SUM_W-1:0]   w_ri_ext;
    logic [mep_pkg::SUM_W-1:0]   w_ri_s;
    logic [mep_pkg::SUM_W-1:0]   w_zr_wide;
    logic [mep_pkg::SUM_W-1:0]   w_zi_wide;
    logic [mep_pkg::SUM_W-1:0]   w_cr_wide;
    logic [mep_pkg::SUM_W-1:0]   w_ci_wide;
    logic                        w_escape;
    logic                        w_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_step  <= mep_pkg::STEP_RESET;
            r_origin_real <= mep_pkg::ORIGIN_REAL_RESET;
            r_origin_imag <= mep_pkg::ORIGIN_IMAG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mep_pkg::CFG_PIXEL_STEP:  r_pixel_step  <= i_cfg_data[mep_pkg::STEP_W-1:0];
                mep_pkg::CFG_ORIGIN_REAL: r_origin_real <= i_cfg_data;
                mep_pkg::CFG_ORIGIN_IMAG: r_origin_imag <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Operand magnitudes; the product signs are recovered from z afterwards.
    assign w_zr_mag = r_zr[mep_pkg::WORD_W-1] ? -r_zr : r_zr;
    assign w_zi_mag = r_zi[mep_pkg::WORD_W-1] ? -r_zi : r_zi;

    // During mapping lanes 0 and 1 form column and row times the step.
    always_comb begin
        if (i_cmd.sel_map) begin
            w_a0 = mep_pkg::WORD_W'(r_col);
            w_b0 = mep_pkg::WORD_W'(r_pixel_step);
            w_a1 = mep_pkg::WORD_W'(r_row);
            w_b1 = mep_pkg::WORD_W'(r_pixel_step);
        end else begin
            w_a0 = w_zr_mag;
            w_b0 = w_zr_mag;
            w_a1 = w_zi_mag;
            w_b1 = w_zi_mag;
        end
    end

    mep_mul u_mul_rr (.i_clk(i_clk), .i_a(w_a0),     .i_b(w_b0),     .o_prod(w_p0));
    mep_mul u_mul_ii (.i_clk(i_clk), .i_a(w_a1),     .i_b(w_b1),     .o_prod(w_p1));
    mep_mul u_mul_ri (.i_clk(i_clk), .i_a(w_zr_mag), .i_b(w_zi_mag), .o_prod(w_p2));

    // Point mapping.
    assign w_cr_wide = f_sext(r_origin_real)
                     + {{(mep_pkg::SUM_W - mep_pkg::MAP_W){1'b0}}, w_p0[mep_pkg::MAP_W-1:0]};
    assign w_ci_wide = f_sext(r_origin_imag)
                     + {{(mep_pkg::SUM_W - mep_pkg::MAP_W){1'b0}}, w_p1[mep_pkg::MAP_W-1:0]};

    // Iteration update and escape test.
    assign w_rr      = f_mag(w_p0);
    assign w_ii      = f_mag(w_p1);
    assign w_ri      = f_mag(w_p2);
    assign w_mag_sum = {1'b0, w_rr} + {1'b0, w_ii};
    assign w_escape  = (w_mag_sum >= mep_pkg::ESC_LIMIT);
    assign w_stop    = (r_n == mep_pkg::N_W'(mep_pkg::MAX_ITER)) || w_escape;

    assign w_ri_ext  = {{(mep_pkg::SUM_W - mep_pkg::MAG_W){1'b0}}, w_ri};
    assign w_ri_s    = (r_zr[mep_pkg::WORD_W-1] ^ r_zi[mep_pkg::WORD_W-1]) ? -w_ri_ext
                                                                          : w_ri_ext;
    assign w_zr_wide = {{(mep_pkg::SUM_W - mep_pkg::MAG_W){1'b0}}, w_rr}
                     - {{(mep_pkg::SUM_W - mep_pkg::MAG_W){1'b0}}, w_ii}
                     + f_sext(r_cr);
    assign w_zi_wide = (w_ri_s << 1) + f_sext(r_ci);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_col <= i_pixel_col;
            r_row <= i_pixel_row;
        end
        if (i_cmd.load_c) begin
            r_cr <= f_sat(w_cr_wide);
            r_ci <= f_sat(w_ci_wide);
            r_zr <= '0;
            r_zi <= '0;
            r_n  <= '0;
        end else if (i_cmd.eval && !w_stop) begin
            r_zr <= f_sat(w_zr_wide);
            r_zi <= f_sat(w_zi_wide);
            r_n  <= r_n + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_red        <= mep_pkg::RED_LUT[r_n];
            r_green      <= mep_pkg::GREEN_LUT[r_n];
            r_blue       <= mep_pkg::BLUE_LUT[r_n];
            r_iter_count <= mep_pkg::COUNT_W'(r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.stop     = w_stop;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_iter_count = r_iter_count;

endmodule

### tb/mandelbrot_escape_pixel_color_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_color_unit_tb
// Drives pixel coordinates into the escape-time color unit under several
// views of the complex plane. A scoreboard predicts the iteration count and
// the three color channels of every pixel and checks each returned color.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_color_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_WAIT       = 600;

    localparam logic [mep_pkg::CFG_IDX_W-1:0] REG_ORDER [3] = '{
        mep_pkg::CFG_PIXEL_STEP, mep_pkg::CFG_ORIGIN_REAL, mep_pkg::CFG_ORIGIN_IMAG
    };

    // Pixels for the default view: corners, alternating bits, and points
    // inside, on and just outside the boundary of the set.
    localparam int N_DIR = 13;
    localparam logic [mep_pkg::PIX_W-1:0] DIR_COL [N_DIR] = '{
        12'd0, 12'd4095, 12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd500,
        12'd350, 12'd300, 12'd552, 12'd554, 12'd350, 12'd400
    };
    localparam logic [mep_pkg::PIX_W-1:0] DIR_ROW [N_DIR] = '{
        12'd0, 12'd4095, 12'd4095, 12'd0, 12'h555, 12'hAAA, 12'd300,
        12'd300, 12'd300, 12'd300, 12'd300, 12'd320, 12'd400
    };

    typedef struct packed {
        logic [mep_pkg::COLOR_W-1:0] red;
        logic [mep_pkg::COLOR_W-1:0] green;
        logic [mep_pkg::COLOR_W-1:0] blue;
        logic [mep_pkg::COUNT_W-1:0] iter_count;
    } t_pixel_color;

    class color_scoreboard;
        t_pixel_color               expected_colors[$];
        logic [mep_pkg::STEP_W-1:0] step;
        longint                     origin_re;
        longint                     origin_im;
        int unsigned                errors;

        function new();
            step      = mep_pkg::STEP_RESET;
            origin_re = sext_word(mep_pkg::ORIGIN_REAL_RESET);
            origin_im = sext_word(mep_pkg::ORIGIN_IMAG_RESET);
            errors    = 0;
        endfunction

        function longint sext_word(logic [mep_pkg::WORD_W-1:0] w);
            return longint'({{(64-mep_pkg::WORD_W){w[mep_pkg::WORD_W-1]}}, w});
        endfunction

        function longint clamp_word(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (mep_pkg::WORD_W - 1)) - 1;
            lo = -(longint'(1) <<< (mep_pkg::WORD_W - 1));
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Product of two Q8.40 values; the magnitude is truncated, so the
        // result rounds toward zero.
        function longint qmul(longint a, longint b);
            logic [127:0] p;
            logic [63:0]  ua;
            logic [63:0]  ub;
            bit           neg;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? -a : a;
            ub  = (b < 0) ? -b : b;
            p   = ua * ub;
            p   = p >> mep_pkg::FRAC_BITS;
            if (p > mep_pkg::MAG_CAP) p = mep_pkg::MAG_CAP;
            return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
        endfunction

        function logic [mep_pkg::COLOR_W-1:0] sat_channel(longint unsigned num,
                                                          longint unsigned den);
            longint unsigned q;
            q = num / den;
            return (q > 255) ? 8'd255 : mep_pkg::COLOR_W'(q);
        endfunction

        function void set_reg(logic [mep_pkg::CFG_IDX_W-1:0] idx,
                              logic [mep_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mep_pkg::CFG_PIXEL_STEP:  step = data[mep_pkg::STEP_W-1:0];
                mep_pkg::CFG_ORIGIN_REAL: origin_re = sext_word(data);
                mep_pkg::CFG_ORIGIN_IMAG: origin_im = sext_word(data);
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [mep_pkg::PIX_W-1:0] col,
                                 logic [mep_pkg::PIX_W-1:0] row);
            longint          cr;
            longint          ci;
            longint          zr;
            longint          zi;
            longint          zr2;
            longint          zi2;
            longint          zri;
            longint          escape;
            longint unsigned n;
            longint unsigned k;
            longint unsigned den;
            t_pixel_color    shade;
            cr     = clamp_word(origin_re + longint'(64'(col) * 64'(step)));
            ci     = clamp_word(origin_im + longint'(64'(row) * 64'(step)));
            zr     = 0;
            zi     = 0;
            n      = 0;
            escape = longint'(4) <<< mep_pkg::FRAC_BITS;
            while (n < mep_pkg::MAX_ITER) begin
                zr2 = qmul(zr, zr);
                zi2 = qmul(zi, zi);
                if (zr2 + zi2 >= escape) break;
                zri = qmul(zr, zi);
                zi  = clamp_word(2 * zri + ci);
                zr  = clamp_word(zr2 - zi2 + cr);
                n++;
            end
            k   = mep_pkg::MAX_ITER - n;
            den = longint'(mep_pkg::MAX_ITER) * mep_pkg::MAX_ITER * mep_pkg::MAX_ITER
                * mep_pkg::MAX_ITER;
            shade.red        = sat_channel(9 * 255 * k * n * n * n, den);
            shade.green      = sat_channel(15 * 255 * k * k * n * n, den);
            shade.blue       = sat_channel(17 * 255 * k * k * k * n, 2 * den);
            shade.iter_count = mep_pkg::COUNT_W'(n);
            expected_colors.push_back(shade);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_color(t_pixel_color got);
            t_pixel_color want;
            if (expected_colors.size() == 0) begin
                $error("color result arrived with no pixel outstanding");
                errors++;
                return;
            end
            want = expected_colors.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("iter_count", want.iter_count, got.iter_count);
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mep_pkg::CFG_DATA_W-1:0] cfg_data;
    bit                             no_idle;
    bit                             rx_long_hold;
    int                             quiet_cycles;
    color_scoreboard                sb = new();

    mep_pixel_if pix_if ();
    mep_color_if color_if ();

    mandelbrot_escape_pixel_color_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_if),
        .o_color     (color_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_pixel_color got;
        got = {color_if.red, color_if.green, color_if.blue, color_if.iter_count};
        if (i_rst_n && pix_if.valid && pix_if.ready)
            sb.note_pixel(pix_if.pixel_col, pix_if.pixel_row);
        if (i_rst_n && color_if.valid && color_if.ready)
            sb.check_color(got);
    end

    // The receiver stalls in random bursts, or once for a long stretch so
    // that the unit fills up and refuses new pixels.
    initial begin
        forever begin
            if (rx_long_hold) begin
                rx_long_hold = 1'b0;
                color_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                color_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                color_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (color_if.valid && color_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Offers one pixel, possibly after a random gap, and returns at the edge
    // where the transaction completes. Valid stays high for the next call.
    task automatic send_pixel(input logic [mep_pkg::PIX_W-1:0] col,
                              input logic [mep_pkg::PIX_W-1:0] row);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.pixel_col <= col;
        pix_if.pixel_row <= row;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [mep_pkg::CFG_DATA_W-1:0] step_data,
                             input logic [mep_pkg::CFG_DATA_W-1:0] re_data,
                             input logic [mep_pkg::CFG_DATA_W-1:0] im_data);
        logic [mep_pkg::CFG_DATA_W-1:0] vals [3];
        vals = '{step_data, re_data, im_data};
        for (int i = 0; i < 3; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.set_reg(REG_ORDER[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [mep_pkg::PIX_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return mep_pkg::PIX_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic run_view(input logic [mep_pkg::CFG_DATA_W-1:0] step_data,
                            input logic [mep_pkg::CFG_DATA_W-1:0] re_data,
                            input logic [mep_pkg::CFG_DATA_W-1:0] im_data,
                            input int count, input int hold_at);
        configure(step_data, re_data, im_data);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) rx_long_hold = 1'b1;
            send_pixel(pick_coord(), pick_coord());
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= mep_pkg::CFG_PIXEL_STEP;
        cfg_data         <= '0;
        pix_if.valid     <= 1'b0;
        pix_if.pixel_col <= '0;
        pix_if.pixel_row <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            send_pixel(DIR_COL[i], DIR_ROW[i]);
        wait_for_results();

        // A zero step puts every pixel on the origin, here at the far corner.
        configure(48'd0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd123, 12'd3000);
        wait_for_results();

        // A step of 4.0 drives the mapping into saturation on both axes.
        configure(48'h0400_0000_0000, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd2048);
        wait_for_results();

        run_view(48'd805306368, -48'sd2473901162496, -48'sd1649267441664, 400, -1);
        run_view(48'd1, -48'sd824633720832, 48'sd109951162778, 100, -1);
        run_view(48'h0400_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 100, -1);
        run_view(48'd137438953, -48'sd879609302221, -48'sd274877906944, 300, 40);
        no_idle = 1'b1;
        // Bits above the step register's width must be dropped.
        run_view({5'b10110, 43'd268435456}, -48'sd2089072092774, -48'sd549755813888,
                 300, -1);

        repeat (END_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
